FILE: hw/rtl/bgr_pkg.sv
// ----------------------------------------------------------------------------
// bgr_pkg: shared definitions for the bit grid toggle/flip/rotate block
// Grid geometry, command codes, the control bundle between the sequencer
// and the grid store, and the row mask and row mirror helpers.
// ----------------------------------------------------------------------------
package bgr_pkg;

	// Grid geometry.
	localparam int MAX_SIZE = 16;
	localparam int ROW_W    = 16;
	localparam int IDX_W    = 4;
	localparam int SIZE_W   = 5;

	typedef logic [ROW_W-1:0]  row_t;
	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [SIZE_W-1:0] size_t;

	// Command codes.
	localparam logic [1:0] FUNC_TOGGLE = 2'd0;
	localparam logic [1:0] FUNC_MIRROR = 2'd1;
	localparam logic [1:0] FUNC_ROTATE = 2'd2;
	localparam logic [1:0] FUNC_BAD    = 2'd3;

	// Reset value of the size register.
	localparam size_t SIZE_RESET = size_t'(MAX_SIZE);

	// Control bundle from the sequencer to the grid store.
	typedef struct packed {
		logic toggle_en;
		idx_t toggle_row;
		idx_t toggle_col;
		logic rot_step_en;
		idx_t rot_j;
		logic rot_commit;
		logic mirror_sel;
		logic mirror_wr_en;
		idx_t row_sel;
	} grid_cmd_t;

	// Mask of the active columns for an active size of 1 to 16.
	function automatic row_t row_mask(input size_t n);
		row_t all_ones;
		all_ones = '1;
		return all_ones >> (size_t'(ROW_W) - n);
	endfunction

	// Reverse the active columns of one row, leaving the others alone.
	function automatic row_t mirror_row(input row_t v, input size_t n);
		row_t rev;
		row_t m;
		for (int k = 0; k < ROW_W; k++) begin
			rev[k] = v[ROW_W-1-k];
		end
		m = row_mask(n);
		return (v & ~m) | ((rev >> (size_t'(ROW_W) - n)) & m);
	endfunction

endpackage

FILE: hw/rtl/bgr_in_if.sv
// ----------------------------------------------------------------------------
// bgr_in_if: command channel
// Valid/ready channel that carries one command item.
// ----------------------------------------------------------------------------
interface bgr_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] func;
	logic [4:0] row_number;
	logic [4:0] column_number;

	modport source (output valid, output func, output row_number,
		output column_number, input ready);
	modport sink (input valid, input func, input row_number,
		input column_number, output ready);
endinterface

FILE: hw/rtl/bgr_out_if.sv
// ----------------------------------------------------------------------------
// bgr_out_if: row dump channel
// Valid/ready channel that carries one emitted grid row or an error item.
// ----------------------------------------------------------------------------
interface bgr_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] row_bits;
	logic [3:0]  row_index;
	logic        last_row;
	logic        error;

	modport source (output valid, output row_bits, output row_index,
		output last_row, output error, input ready);
	modport sink (input valid, input row_bits, input row_index,
		input last_row, input error, output ready);
endinterface

FILE: hw/rtl/bit_grid_toggle_flip_rotate_core.sv
// ----------------------------------------------------------------------------
// bit_grid_toggle_flip_rotate_core: square bit grid with toggle/flip/rotate
// Top level: size register, grid store and command sequencer.
// Toggle and mirror go from the taken item straight to the row dump; rotate
// first makes n read steps through the one row port, then a commit state.
// A dump then gives one row per cycle while the output is not stalled, n rows.
// A new item is taken only once the previous dump or error item is loaded.
// Reset: asynchronous, clears the grid and halt flag and sets the size to 16.
// ----------------------------------------------------------------------------
module bit_grid_toggle_flip_rotate_core
	import bgr_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic [4:0] cfg_wdata,
	bgr_in_if.sink    in_ch,
	bgr_out_if.source out_ch
);

	size_t     grid_size_q;
	size_t     active_n;
	grid_cmd_t cmd;
	row_t      rd_view;

	// Size register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_size_q <= SIZE_RESET;
		end else if (cfg_we) begin
			grid_size_q <= cfg_wdata;
		end
	end

	// Active size, saturated to 1..MAX_SIZE.
	always_comb begin
		if (grid_size_q == '0) begin
			active_n = size_t'(1);
		end else if (grid_size_q > size_t'(MAX_SIZE)) begin
			active_n = size_t'(MAX_SIZE);
		end else begin
			active_n = grid_size_q;
		end
	end

	bgr_grid u_grid (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.active_n (active_n),
		.rd_view  (rd_view)
	);

	bgr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.out_ch   (out_ch),
		.active_n (active_n),
		.rd_view  (rd_view),
		.cmd      (cmd)
	);

endmodule

FILE: hw/rtl/bgr_grid.sv
// ----------------------------------------------------------------------------
// bgr_grid: grid store with the shared row read and mirror unit
// Holds the grid rows and a scratch grid for rotation. One row is read per
// cycle through a single read port, optionally mirrored, and either written
// back or scattered into one column of the scratch grid.
// ----------------------------------------------------------------------------
module bgr_grid
	import bgr_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  grid_cmd_t cmd,
	input  size_t     active_n,
	output row_t      rd_view
);

	row_t grid_q [MAX_SIZE];
	row_t tmp_q  [MAX_SIZE];
	row_t rd_raw;
	row_t act_mask;

	// Shared read port and mirror unit.
	assign rd_raw   = grid_q[cmd.row_sel];
	assign act_mask = row_mask(active_n);
	assign rd_view  = cmd.mirror_sel ? mirror_row(rd_raw, active_n) : rd_raw;

	// Grid rows: rotation commit, single cell toggle, mirrored write back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_SIZE; i++) begin
				grid_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < MAX_SIZE; i++) begin
				if (cmd.rot_commit && (size_t'(i) < active_n)) begin
					grid_q[i] <= (grid_q[i] & ~act_mask) | (tmp_q[i] & act_mask);
				end else if (cmd.toggle_en && (cmd.toggle_row == idx_t'(i))) begin
					grid_q[i] <= grid_q[i] ^ (row_t'(1) << cmd.toggle_col);
				end else if (cmd.mirror_wr_en && (cmd.row_sel == idx_t'(i))) begin
					grid_q[i] <= rd_view;
				end
			end
		end
	end

	// Scratch grid: bit i of the row read goes to column j of new row i.
	always_ff @(posedge clk) begin
		if (cmd.rot_step_en) begin
			for (int i = 0; i < MAX_SIZE; i++) begin
				tmp_q[i][cmd.rot_j] <= rd_raw[i];
			end
		end
	end

endmodule

FILE: hw/rtl/bgr_ctrl.sv
// ----------------------------------------------------------------------------
// bgr_ctrl: command sequencer and output register
// Decodes each command item, steps the grid store through rotation and the
// row dump, keeps the halt flag and drives the registered output channel.
// ----------------------------------------------------------------------------
module bgr_ctrl
	import bgr_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	bgr_in_if.sink    in_ch,
	bgr_out_if.source out_ch,
	input  size_t     active_n,
	input  row_t      rd_view,
	output grid_cmd_t cmd
);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_ROT    = 5'b00010,
		S_COMMIT = 5'b00100,
		S_DUMP   = 5'b01000,
		S_ERR    = 5'b10000
	} state_t;

	state_t state_q, state_d;
	idx_t   cnt_q, cnt_d;
	logic   mirror_q, mirror_d;
	logic   halted_q, halted_d;
	idx_t   nm1;
	logic   toggle_ok;
	logic   slot_free;
	logic   load;
	row_t   ld_bits;
	idx_t   ld_idx;
	logic   ld_last;
	logic   ld_err;

	logic   out_valid_q;
	row_t   row_bits_q;
	idx_t   row_index_q;
	logic   last_row_q;
	logic   error_q;

	assign nm1       = idx_t'(active_n - size_t'(1));
	assign slot_free = !out_valid_q || out_ch.ready;
	assign toggle_ok = (in_ch.row_number != '0) && (in_ch.row_number <= active_n) &&
		(in_ch.column_number != '0) && (in_ch.column_number <= active_n);
	assign in_ch.ready = (state_q == S_IDLE);

	// Sequencer.
	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		mirror_d = mirror_q;
		halted_d = halted_q;
		cmd      = '0;
		load     = 1'b0;
		ld_bits  = '0;
		ld_idx   = '0;
		ld_last  = 1'b0;
		ld_err   = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_ch.valid) begin
					cnt_d = '0;
					if (halted_q) begin
						state_d = S_ERR;
					end else begin
						case (in_ch.func)
							FUNC_TOGGLE: begin
								if (toggle_ok) begin
									cmd.toggle_en  = 1'b1;
									cmd.toggle_row = idx_t'(in_ch.row_number - 5'd1);
									cmd.toggle_col = idx_t'(in_ch.column_number - 5'd1);
									mirror_d       = 1'b0;
									state_d        = S_DUMP;
								end else begin
									halted_d = 1'b1;
									state_d  = S_ERR;
								end
							end
							FUNC_MIRROR: begin
								mirror_d = 1'b1;
								state_d  = S_DUMP;
							end
							FUNC_ROTATE: begin
								state_d = S_ROT;
							end
							default: begin
								halted_d = 1'b1;
								state_d  = S_ERR;
							end
						endcase
					end
				end
			end
			S_ROT: begin
				// Old row n-1-j fills column j of the scratch grid.
				cmd.row_sel     = idx_t'(nm1 - cnt_q);
				cmd.rot_step_en = 1'b1;
				cmd.rot_j       = cnt_q;
				if (cnt_q == nm1) begin
					state_d = S_COMMIT;
				end else begin
					cnt_d = cnt_q + idx_t'(1);
				end
			end
			S_COMMIT: begin
				cmd.rot_commit = 1'b1;
				mirror_d       = 1'b0;
				cnt_d          = '0;
				state_d        = S_DUMP;
			end
			S_DUMP: begin
				cmd.row_sel    = cnt_q;
				cmd.mirror_sel = mirror_q;
				if (slot_free) begin
					load             = 1'b1;
					ld_bits          = rd_view & row_mask(active_n);
					ld_idx           = cnt_q;
					ld_last          = (cnt_q == nm1);
					cmd.mirror_wr_en = mirror_q;
					if (cnt_q == nm1) begin
						state_d = S_IDLE;
					end else begin
						cnt_d = cnt_q + idx_t'(1);
					end
				end
			end
			S_ERR: begin
				if (slot_free) begin
					load    = 1'b1;
					ld_last = 1'b1;
					ld_err  = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			mirror_q    <= 1'b0;
			halted_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			cnt_q    <= cnt_d;
			mirror_q <= mirror_d;
			halted_q <= halted_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (load) begin
			row_bits_q  <= ld_bits;
			row_index_q <= ld_idx;
			last_row_q  <= ld_last;
			error_q     <= ld_err;
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.row_bits  = row_bits_q;
	assign out_ch.row_index = row_index_q;
	assign out_ch.last_row  = last_row_q;
	assign out_ch.error     = error_q;

	// An error item is a single, empty, final row.
	a_err_item: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && error_q) |-> (last_row_q && (row_bits_q == '0) &&
		(row_index_q == '0)))
		else $error("error item carries row data");

	// Once halted, the block stays halted until reset.
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q)
		else $error("halt flag cleared without reset");

	// Any item taken while halted answers with an error item.
	a_halt_err: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready && halted_q) |=> (state_q == S_ERR))
		else $error("halted block did not answer with an error");

	// The last rotation step is followed by the commit.
	a_rot_commit: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_ROT) && (cnt_q == nm1)) |=> (state_q == S_COMMIT))
		else $error("rotation did not commit after its last step");

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for bit_grid_toggle_flip_rotate_core
// Commands go in through a queue-fed driver with random bursts and gaps. The
// row dumps are checked field by field against a local model of the grid,
// and the grid size is changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb;
	import bgr_pkg::*;

	localparam int LATENCY_WAIT   = 40;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int LONG_HOLD      = 300;
	localparam int HOLD_AFTER     = 30;
	localparam int RANDOM_PHASES  = 8;
	localparam int PHASE_ITEMS    = 16;

	typedef struct {
		logic [1:0] func;
		logic [4:0] row_number;
		logic [4:0] column_number;
	} cmd_item_t;

	typedef struct {
		row_t bits;
		idx_t index;
		logic last;
		logic err;
	} dump_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [4:0]  cfg_wdata;

	bgr_in_if  in_ch();
	bgr_out_if out_ch();

	bit_grid_toggle_flip_rotate_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	// Grid model and its configuration.
	row_t  grid_model [MAX_SIZE];
	logic  grid_halted;
	size_t size_model;

	cmd_item_t pending_cmds [$];
	dump_row_t expected_rows [$];

	cmd_item_t next_cmd;
	dump_row_t want;
	int        mismatches;
	int        in_accepted;
	int        burst_left;
	int        gap_left;
	int        stall_left;
	logic      hold_done;
	int        ready_mode;
	int        mode_left;
	int        idle_cycles;

	// Clock.
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Active side length: the size register saturated to 1..16.
	function automatic int active_rows(input size_t s);
		if (s == 0) begin
			return 1;
		end
		if (int'(s) > MAX_SIZE) begin
			return MAX_SIZE;
		end
		return int'(s);
	endfunction

	// Apply one command to the model and queue the rows it dumps.
	task automatic grid_execute(input cmd_item_t c);
		int   n;
		logic bad;
		row_t src;
		row_t turned [MAX_SIZE];
		row_t active_mask;
		n = active_rows(size_model);
		bad = grid_halted;
		active_mask = row_t'((32'd1 << n) - 1);
		if (!bad) begin
			case (c.func)
				FUNC_TOGGLE: begin
					if (c.row_number == 0 || int'(c.row_number) > n ||
						c.column_number == 0 || int'(c.column_number) > n) begin
						bad = 1'b1;
					end else begin
						grid_model[c.row_number-1][c.column_number-1] =
							~grid_model[c.row_number-1][c.column_number-1];
					end
				end
				FUNC_MIRROR: begin
					for (int i = 0; i < n; i++) begin
						src = grid_model[i];
						for (int k = 0; k < n; k++) begin
							grid_model[i][k] = src[n-1-k];
						end
					end
				end
				FUNC_ROTATE: begin
					// Cell (i, j) takes the old cell (n-1-j, i).
					for (int i = 0; i < n; i++) begin
						turned[i] = grid_model[i];
						for (int j = 0; j < n; j++) begin
							turned[i][j] = grid_model[n-1-j][i];
						end
					end
					for (int i = 0; i < n; i++) begin
						grid_model[i] = turned[i];
					end
				end
				default: begin
					bad = 1'b1;
				end
			endcase
		end
		if (bad) begin
			// A bad command, or any item while halted, gives one error row.
			grid_halted = 1'b1;
			expected_rows.push_back('{row_t'(0), idx_t'(0), 1'b1, 1'b1});
		end else begin
			for (int i = 0; i < n; i++) begin
				expected_rows.push_back('{grid_model[i] & active_mask, idx_t'(i),
					i == n - 1, 1'b0});
			end
		end
	endtask

	task automatic queue_cmd(input logic [1:0] f, input int r, input int c);
		pending_cmds.push_back('{f, 5'(r), 5'(c)});
	endtask

	// Well-formed commands with random content for the current size.
	task automatic queue_random_cmds(input int count);
		int n;
		int sel;
		n = active_rows(size_model);
		for (int i = 0; i < count; i++) begin
			sel = $urandom_range(0, 9);
			if (sel < 6) begin
				queue_cmd(FUNC_TOGGLE, $urandom_range(1, n), $urandom_range(1, n));
			end else if (sel < 8) begin
				queue_cmd(FUNC_MIRROR, $urandom_range(0, 31), $urandom_range(0, 31));
			end else begin
				queue_cmd(FUNC_ROTATE, $urandom_range(0, 31), $urandom_range(0, 31));
			end
		end
	endtask

	// The sender pauses here until every expected row has come back.
	task automatic wait_grid_idle();
		do begin
			@(negedge clk);
		end while (pending_cmds.size() != 0 || in_ch.valid || expected_rows.size() != 0);
		repeat (LATENCY_WAIT) @(posedge clk);
	endtask

	task automatic set_grid_size(input size_t v);
		wait_grid_idle();
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		size_model = v;
	endtask

	// Command driver: bursts of random length with random gaps.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			burst_left  <= 0;
			gap_left    <= 0;
		end else if (!in_ch.valid || in_ch.ready) begin
			if (gap_left != 0) begin
				in_ch.valid <= 1'b0;
				gap_left    <= gap_left - 1;
			end else if (pending_cmds.size() != 0) begin
				next_cmd = pending_cmds.pop_front();
				in_ch.valid         <= 1'b1;
				in_ch.func          <= next_cmd.func;
				in_ch.row_number    <= next_cmd.row_number;
				in_ch.column_number <= next_cmd.column_number;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 12);
					gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// Row receiver: changing stall patterns, plus one long hold-off.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			stall_left   <= 0;
			hold_done    <= 1'b0;
			ready_mode   <= 0;
			mode_left    <= 0;
		end else if (stall_left != 0) begin
			out_ch.ready <= 1'b0;
			stall_left   <= stall_left - 1;
		end else if (!hold_done && in_accepted >= HOLD_AFTER) begin
			out_ch.ready <= 1'b0;
			stall_left   <= LONG_HOLD;
			hold_done    <= 1'b1;
		end else begin
			if (mode_left == 0) begin
				ready_mode <= $urandom_range(0, 2);
				mode_left  <= $urandom_range(10, 60);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (ready_mode)
				0:       out_ch.ready <= 1'b1;
				1:       out_ch.ready <= 1'($urandom_range(0, 1));
				default: out_ch.ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// Monitor: predict on each accepted command, check each accepted row.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready) begin
				grid_execute('{in_ch.func, in_ch.row_number, in_ch.column_number});
				in_accepted <= in_accepted + 1;
			end
			if (out_ch.valid && out_ch.ready) begin
				if (expected_rows.size() == 0) begin
					$display("%0t: unexpected row: bits %h index %0d last %b error %b",
						$time, out_ch.row_bits, out_ch.row_index, out_ch.last_row,
						out_ch.error);
					mismatches++;
				end else begin
					want = expected_rows.pop_front();
					if (out_ch.row_bits !== want.bits) begin
						$display("%0t: row_bits mismatch: expected %h actual %h",
							$time, want.bits, out_ch.row_bits);
						mismatches++;
					end
					if (out_ch.row_index !== want.index) begin
						$display("%0t: row_index mismatch: expected %0d actual %0d",
							$time, want.index, out_ch.row_index);
						mismatches++;
					end
					if (out_ch.last_row !== want.last) begin
						$display("%0t: last_row mismatch: expected %b actual %b",
							$time, want.last, out_ch.last_row);
						mismatches++;
					end
					if (out_ch.error !== want.err) begin
						$display("%0t: error mismatch: expected %b actual %b",
							$time, want.err, out_ch.error);
						mismatches++;
					end
				end
			end
		end
	end

	// Watchdog on cycles in which neither channel moves an item.
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog expired with %0d rows outstanding",
				$time, expected_rows.size());
			$display("Regression FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Stimulus sequence.
	initial begin
		int n;
		size_t phase_size;
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_wdata           = '0;
		in_ch.valid         = 1'b0;
		in_ch.func          = FUNC_TOGGLE;
		in_ch.row_number    = '0;
		in_ch.column_number = '0;
		out_ch.ready        = 1'b0;
		mismatches          = 0;
		in_accepted         = 0;
		idle_cycles         = 0;
		for (int i = 0; i < MAX_SIZE; i++) begin
			grid_model[i] = '0;
		end
		grid_halted = 1'b0;
		size_model  = SIZE_RESET;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: corner cells, toggle, mirror and rotate, ignored fields at extremes.
		queue_cmd(FUNC_TOGGLE, 1, 1);
		queue_cmd(FUNC_TOGGLE, 16, 16);
		queue_cmd(FUNC_TOGGLE, 1, 16);
		queue_cmd(FUNC_TOGGLE, 16, 1);
		queue_cmd(FUNC_TOGGLE, 7, 10);
		queue_cmd(FUNC_MIRROR, 31, 31);
		queue_cmd(FUNC_ROTATE, 0, 0);
		queue_cmd(FUNC_ROTATE, 16, 1);
		queue_cmd(FUNC_MIRROR, 0, 31);
		queue_cmd(FUNC_TOGGLE, 1, 1);

		// Smallest grid, and a size of zero that acts as one.
		set_grid_size(5'd1);
		queue_cmd(FUNC_TOGGLE, 1, 1);
		queue_cmd(FUNC_MIRROR, 5, 5);
		queue_cmd(FUNC_ROTATE, 0, 0);
		set_grid_size(5'd0);
		queue_cmd(FUNC_TOGGLE, 1, 1);
		queue_cmd(FUNC_ROTATE, 31, 31);

		// Sizes above the limit act as sixteen.
		set_grid_size(5'd31);
		queue_cmd(FUNC_ROTATE, 0, 0);
		queue_cmd(FUNC_MIRROR, 31, 0);
		queue_cmd(FUNC_TOGGLE, 16, 16);
		set_grid_size(5'd17);
		queue_cmd(FUNC_TOGGLE, 16, 16);

		// Random phases, each with its own grid size.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0:       phase_size = 5'd16;
				1:       phase_size = 5'd2;
				2:       phase_size = 5'd3;
				5:       phase_size = 5'd31;
				default: phase_size = 5'($urandom_range(0, 31));
			endcase
			set_grid_size(phase_size);
			queue_random_cmds(PHASE_ITEMS);
		end

		// A bad command halts the block; everything after it is an error.
		wait_grid_idle();
		n = active_rows(size_model);
		case ($urandom_range(0, 4))
			0:       queue_cmd(FUNC_BAD, $urandom_range(0, 31), $urandom_range(0, 31));
			1:       queue_cmd(FUNC_TOGGLE, 0, $urandom_range(1, n));
			2:       queue_cmd(FUNC_TOGGLE, $urandom_range(1, n), 0);
			3:       queue_cmd(FUNC_TOGGLE, $urandom_range(n + 1, 31), $urandom_range(1, n));
			default: queue_cmd(FUNC_TOGGLE, $urandom_range(1, n), $urandom_range(n + 1, 31));
		endcase
		for (int i = 0; i < 6; i++) begin
			queue_cmd(2'($urandom_range(0, 3)), $urandom_range(0, 31), $urandom_range(0, 31));
		end
		set_grid_size(5'($urandom_range(1, 16)));
		for (int i = 0; i < 4; i++) begin
			queue_cmd(2'($urandom_range(0, 3)), $urandom_range(0, 31), $urandom_range(0, 31));
		end

		wait_grid_idle();
		if (mismatches == 0 && expected_rows.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
